/* hw/rtl/tnsr_pkg.sv */
// Package for the two-nation shipping revenue aggregate unit.
// Holds request kinds, register indexes, field widths and controller/datapath structs.
// No dependencies.
package tnsr_pkg;

    // Field widths fixed by the request and result formats
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 14;
    localparam int NATION_W = 5;
    localparam int DAY_W    = 16;
    localparam int PRICE_W  = 32;
    localparam int YEAR_W   = 11;
    localparam int REV_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_BINS   = 8;
    localparam int BIN_IDX_W  = 3;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ITEM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NATION_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NATION_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIP_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIP_STOP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YEAR_SPLIT = 3'd4;

    // Register reset values
    localparam logic [NATION_W-1:0]     NATION_A_RST   = 5'd6;
    localparam logic [NATION_W-1:0]     NATION_B_RST   = 5'd7;
    localparam logic signed [DAY_W-1:0] SHIP_START_RST = 16'sd0;
    localparam logic signed [DAY_W-1:0] SHIP_STOP_RST  = 16'sd730;
    localparam logic signed [DAY_W-1:0] YEAR_SPLIT_RST = 16'sd365;

    // Year labels of the two year bins
    localparam logic [YEAR_W-1:0] YEAR_FIRST  = 11'd1995;
    localparam logic [YEAR_W-1:0] YEAR_SECOND = 11'd1996;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_step;    // write one cleared store entry
        logic take;        // a request is accepted this cycle
        logic accum;       // add the looked-up line item into its bin
        logic flush_step;  // visit the current bin of a flush
    } tnsr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;    // clearing pass is at its final entry
        logic step_ok;     // current flush bin can be visited now
        logic idx_last;    // current flush bin is the final one
    } tnsr_sts_t;

endpackage

/* hw/rtl/tnsr_if.sv */
// Stream interfaces for requests and results of the revenue aggregate unit.
// Depends on tnsr_pkg for field widths.
interface tnsr_in_if;
    import tnsr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [KEY_W-1:0]           supplier_key;
    logic [NATION_W-1:0]        supplier_nation;
    logic [NATION_W-1:0]        customer_nation;
    logic signed [DAY_W-1:0]    ship_day;
    logic signed [PRICE_W-1:0]  price;

    modport source (output valid, kind, supplier_key, supplier_nation, customer_nation,
                    ship_day, price, input ready);
    modport sink   (input valid, kind, supplier_key, supplier_nation, customer_nation,
                    ship_day, price, output ready);
endinterface

interface tnsr_out_if;
    import tnsr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [NATION_W-1:0]      supplier_nation_out;
    logic [NATION_W-1:0]      customer_nation_out;
    logic [YEAR_W-1:0]        ship_year;
    logic signed [REV_W-1:0]  revenue;
    logic                     last;

    modport source (output valid, supplier_nation_out, customer_nation_out, ship_year,
                    revenue, last, input ready);
    modport sink   (input valid, supplier_nation_out, customer_nation_out, ship_year,
                    revenue, last, output ready);
endinterface

/* hw/rtl/tnsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tnsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hw/rtl/tnsr_ctrl.sv */
// Controller state machine of the revenue aggregate unit.
// Depends on tnsr_pkg for request kinds and the command/status structs.
module tnsr_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [tnsr_pkg::KIND_W-1:0] in_kind,
    output logic                      in_ready,
    output tnsr_pkg::tnsr_cmd_t       cmd,
    input  tnsr_pkg::tnsr_sts_t       sts
);
    import tnsr_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Decode commands and next state
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.clr_step   = 1'b0;
        cmd.take       = 1'b0;
        cmd.accum      = 1'b0;
        cmd.flush_step = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && in_kind == KIND_ITEM)
                begin
                    state_next = ST_LOOK;
                end
                else if (in_valid && in_kind == KIND_FLUSH)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_LOOK:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                cmd.flush_step = sts.step_ok;
                if (sts.step_ok && sts.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

/* hw/rtl/tnsr_dp.sv */
// Datapath of the revenue aggregate unit: registers, nation store, bins, output register.
// Depends on tnsr_pkg and tnsr_ram.
module tnsr_dp #(
    parameter int SUPPLIER_KEYS = 16384
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tnsr_pkg::tnsr_cmd_t                 cmd,
    output tnsr_pkg::tnsr_sts_t                 sts,
    input  logic                                cfg_we,
    input  logic [tnsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tnsr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [tnsr_pkg::KIND_W-1:0]         in_kind,
    input  logic [tnsr_pkg::KEY_W-1:0]          in_supplier_key,
    input  logic [tnsr_pkg::NATION_W-1:0]       in_supplier_nation,
    input  logic [tnsr_pkg::NATION_W-1:0]       in_customer_nation,
    input  logic signed [tnsr_pkg::DAY_W-1:0]   in_ship_day,
    input  logic signed [tnsr_pkg::PRICE_W-1:0] in_price,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tnsr_pkg::NATION_W-1:0]       out_supplier_nation,
    output logic [tnsr_pkg::NATION_W-1:0]       out_customer_nation,
    output logic [tnsr_pkg::YEAR_W-1:0]         out_ship_year,
    output logic signed [tnsr_pkg::REV_W-1:0]   out_revenue,
    output logic                                out_last
);
    import tnsr_pkg::*;

    localparam int AW = $clog2(SUPPLIER_KEYS);
    localparam int XW = (AW > KEY_W) ? AW + 1 : KEY_W + 1;
    localparam int EW = NATION_W + 1;

    // Configuration registers
    logic [NATION_W-1:0]     nation_a_reg;
    logic [NATION_W-1:0]     nation_b_reg;
    logic signed [DAY_W-1:0] ship_start_reg;
    logic signed [DAY_W-1:0] ship_stop_reg;
    logic signed [DAY_W-1:0] year_split_reg;

    // Line item held for the lookup cycle
    logic [NATION_W-1:0]     cnat_reg;
    logic [PRICE_W-1:0]      price_reg;
    logic                    year_reg;
    logic                    keep_reg;

    // Clearing pass, bins and flush walk
    logic [AW-1:0]           clr_cnt_reg;
    logic [REV_W-1:0]        bins_reg [NUM_BINS];
    logic [NUM_BINS-1:0]     mask_reg;
    logic [BIN_IDX_W-1:0]    idx_reg;

    // Output register
    logic                    out_valid_reg;
    logic [NATION_W-1:0]     out_snat_reg;
    logic [NATION_W-1:0]     out_cnat_reg;
    logic [YEAR_W-1:0]       out_year_reg;
    logic [REV_W-1:0]        out_rev_reg;
    logic                    out_last_reg;

    logic [XW-1:0]           key_x;
    logic                    key_in_range;
    logic [AW-1:0]           key_addr;
    logic                    same_mode;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [EW-1:0]           ram_wdata;
    logic                    ram_re;
    logic [EW-1:0]           entry;
    logic                    s_is_a;
    logic                    s_is_b;
    logic                    c_is_a;
    logic                    c_is_b;
    logic                    pair_ok;
    logic                    hit;
    logic [BIN_IDX_W-1:0]    acc_idx;
    logic [NUM_BINS-1:0]     cand;
    logic [NUM_BINS-1:0]     hi_mask;
    logic                    out_free;
    logic                    do_load;

    assign same_mode    = (nation_a_reg == nation_b_reg);
    assign key_x        = XW'(in_supplier_key);
    assign key_in_range = (key_x < XW'(SUPPLIER_KEYS));
    assign key_addr     = key_x[AW-1:0];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nation_a_reg   <= NATION_A_RST;
            nation_b_reg   <= NATION_B_RST;
            ship_start_reg <= SHIP_START_RST;
            ship_stop_reg  <= SHIP_STOP_RST;
            year_split_reg <= YEAR_SPLIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NATION_A:   nation_a_reg   <= cfg_wdata[NATION_W-1:0];
                REG_NATION_B:   nation_b_reg   <= cfg_wdata[NATION_W-1:0];
                REG_SHIP_START: ship_start_reg <= cfg_wdata;
                REG_SHIP_STOP:  ship_stop_reg  <= cfg_wdata;
                REG_YEAR_SPLIT: year_split_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Store port: clearing pass or supplier load writes, line item reads
    assign ram_we    = cmd.clr_step || (cmd.take && in_kind == KIND_LOAD && key_in_range);
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : key_addr;
    assign ram_wdata = cmd.clr_step ? '0 : {1'b1, in_supplier_nation};
    assign ram_re    = cmd.take && in_kind == KIND_ITEM;

    tnsr_ram #(
        .WIDTH (EW),
        .DEPTH (SUPPLIER_KEYS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (key_addr),
        .rdata (entry)
    );

    // Advance the clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign sts.clr_last = (clr_cnt_reg == AW'(SUPPLIER_KEYS - 1));

    // Hold the line item fields for the lookup cycle
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            cnat_reg  <= in_customer_nation;
            price_reg <= in_price;
            year_reg  <= (in_ship_day >= year_split_reg);
            keep_reg  <= key_in_range && (in_ship_day >= ship_start_reg)
                         && (in_ship_day <= ship_stop_reg);
        end
    end

    // Tag both sides with the current nations
    always_comb
    begin
        s_is_a  = (entry[NATION_W-1:0] == nation_a_reg);
        s_is_b  = !same_mode && (entry[NATION_W-1:0] == nation_b_reg);
        c_is_a  = (cnat_reg == nation_a_reg);
        c_is_b  = !same_mode && (cnat_reg == nation_b_reg);
        pair_ok = same_mode ? (s_is_a && c_is_a) : (s_is_a != c_is_a);
        hit     = keep_reg && entry[NATION_W] && (s_is_a || s_is_b)
                  && (c_is_a || c_is_b) && pair_ok;
        acc_idx = {!s_is_a, !c_is_a, year_reg};
    end

    // Flush candidates: allowed pairs with a nonzero sum
    always_comb
    begin
        for (int b = 0; b < NUM_BINS; b++)
        begin
            cand[b] = (bins_reg[b] != '0)
                      && (same_mode ? (b[2:1] == 2'b00) : (b[2] != b[1]));
        end
    end

    assign hi_mask      = NUM_BINS'(8'hFE << idx_reg);
    assign out_free     = !out_valid_reg || out_ready;
    assign do_load      = cmd.flush_step && mask_reg[idx_reg];
    assign sts.step_ok  = !mask_reg[idx_reg] || out_free;
    assign sts.idx_last = (idx_reg == BIN_IDX_W'(NUM_BINS - 1));

    // Accumulate kept prices, clear on the final flush visit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BINS; b++)
            begin
                bins_reg[b] <= '0;
            end
        end
        else if (cmd.flush_step && sts.idx_last)
        begin
            for (int b = 0; b < NUM_BINS; b++)
            begin
                bins_reg[b] <= '0;
            end
        end
        else if (cmd.accum && hit)
        begin
            bins_reg[acc_idx] <= bins_reg[acc_idx]
                                 + {{(REV_W - PRICE_W){price_reg[PRICE_W-1]}}, price_reg};
        end
    end

    // Capture the flush mask and walk the bins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            idx_reg  <= '0;
        end
        else if (cmd.take && in_kind == KIND_FLUSH)
        begin
            mask_reg <= cand;
            idx_reg  <= '0;
        end
        else if (cmd.flush_step)
        begin
            idx_reg <= idx_reg + BIN_IDX_W'(1);
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            out_snat_reg <= idx_reg[2] ? nation_b_reg : nation_a_reg;
            out_cnat_reg <= idx_reg[1] ? nation_b_reg : nation_a_reg;
            out_year_reg <= idx_reg[0] ? YEAR_SECOND : YEAR_FIRST;
            out_rev_reg  <= bins_reg[idx_reg];
            out_last_reg <= ~|(mask_reg & hi_mask);
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_supplier_nation = out_snat_reg;
    assign out_customer_nation = out_cnat_reg;
    assign out_ship_year       = out_year_reg;
    assign out_revenue         = out_rev_reg;
    assign out_last            = out_last_reg;
endmodule

/* hw/rtl/two_nation_shipping_revenue_aggregate_unit.sv */
// Top level of the two-nation shipping revenue aggregate unit.
// Depends on tnsr_pkg, tnsr_if, tnsr_ctrl and tnsr_dp.
//
// Requests come in three kinds. A supplier load writes the supplier's nation into a
// per-key store. A line item reads that store, tags supplier and customer against
// nation_a and nation_b, checks the ship window and adds its price into one of eight
// 64-bit bins; the registered store read comes first, then the tag and add. A flush
// walks the eight bins one per cycle while the result side does not stall, sends
// every nonzero bin of an allowed nation pair, last set on the final one, then
// clears the bins. A result waits in an output register, so the next request is
// taken while it is still pending. After reset the store is cleared one entry per
// cycle, all SUPPLIER_KEYS entries; no request is taken during that pass, register
// writes are. Registers should be written only while the unit is idle.
module two_nation_shipping_revenue_aggregate_unit #(
    parameter int SUPPLIER_KEYS = 16384
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tnsr_in_if.sink                         in_ch,
    tnsr_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [tnsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tnsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tnsr_pkg::*;

    tnsr_cmd_t cmd;
    tnsr_sts_t sts;

    // Sequence each request
    tnsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Store, bins and output register
    tnsr_dp #(
        .SUPPLIER_KEYS (SUPPLIER_KEYS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .in_kind             (in_ch.kind),
        .in_supplier_key     (in_ch.supplier_key),
        .in_supplier_nation  (in_ch.supplier_nation),
        .in_customer_nation  (in_ch.customer_nation),
        .in_ship_day         (in_ch.ship_day),
        .in_price            (in_ch.price),
        .out_valid           (out_ch.valid),
        .out_ready           (out_ch.ready),
        .out_supplier_nation (out_ch.supplier_nation_out),
        .out_customer_nation (out_ch.customer_nation_out),
        .out_ship_year       (out_ch.ship_year),
        .out_revenue         (out_ch.revenue),
        .out_last            (out_ch.last)
    );

    // A line item or flush keeps the unit busy for the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.kind == KIND_ITEM || in_ch.kind == KIND_FLUSH))
        |=> !in_ch.ready)
        else $error("request taken right after a line item or flush");

    // A supplier load never blocks the next request
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.kind == KIND_LOAD) |=> in_ch.ready)
        else $error("supplier load stalled the request side");

    // Every result carries one of the two year labels
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.ship_year == YEAR_FIRST || out_ch.ship_year == YEAR_SECOND))
        else $error("result with bad year label");
endmodule
